[rtl/wbr_pkg.sv]
// Shared types, widths and the semitone ratio table of the wavetable box resampler.
// No dependencies; every other file of the block imports this package.

package wbr_pkg;

    // Default sizes, handed down from the top level
    localparam int TABLE_COUNT_DEF  = 32;
    localparam int TABLE_LENGTH_DEF = 4096;
    localparam int NOTE_MAX_DEF     = 127;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int NOTE_W   = 7;
    localparam int NUM_W    = 32;
    localparam int TBL_W    = 5;
    localparam int ADDR_W   = 12;

    // Fixed-point layout: positions and ratios are Q.16
    localparam int FRAC_W   = 16;
    localparam int ROM_W    = 17;
    localparam int QUO_W    = 17;
    localparam int STEP_W   = 5;

    localparam logic [QUO_W-1:0] RES_MAX = QUO_W'(32767);

    // Input word commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr;      // store one sample
        logic cap;     // capture a read word
        logic ratio;   // form the pitch ratio
        logic rmod;    // reduce the ratio by the table span
        logic mdbl;    // modular multiply: double
        logic madd;    // modular multiply: conditional add
        logic span;    // split the window start into index and fractions
        logic rd;      // issue one table read
        logic dinit;   // load the divider
        logic dstep;   // one quotient bit
        logic oload;   // load the output register
        logic ozero;   // output zero instead of the quotient
    } wbr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic tbl_ok;  // active table exists
        logic rm_ge;   // ratio still at or above the table span
        logic last;    // next read is the last of the window
        logic busy;    // read pipeline still holds terms
    } wbr_sts_t;

    // round(2^(k/12) * 65536) for k = 0..11
    function automatic logic [ROM_W-1:0] octave_ratio(input logic [3:0] semi);
        logic [ROM_W-1:0] val;
        unique case (semi)
            4'd0:    val = 17'd65536;
            4'd1:    val = 17'd69433;
            4'd2:    val = 17'd73562;
            4'd3:    val = 17'd77936;
            4'd4:    val = 17'd82570;
            4'd5:    val = 17'd87480;
            4'd6:    val = 17'd92682;
            4'd7:    val = 17'd98193;
            4'd8:    val = 17'd104032;
            4'd9:    val = 17'd110218;
            4'd10:   val = 17'd116772;
            4'd11:   val = 17'd123715;
            default: val = 17'd65536;
        endcase
        return val;
    endfunction

endpackage

[rtl/wbr_store.sv]
// Wavetable sample memory: one write port, one read port with registered data.
// Depends on wbr_pkg for the sample width.

module wbr_store
    import wbr_pkg::*;
#(
    parameter int DEPTH = TABLE_COUNT_DEF * TABLE_LENGTH_DEF,
    parameter int AW    = $clog2(TABLE_COUNT_DEF * TABLE_LENGTH_DEF)
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Write one sample
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read one sample, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/wbr_dp.sv]
// Datapath of the wavetable box resampler: ratio, modular position, window walk,
// edge weighting, accumulation, rounding divider and output register.
// Depends on wbr_pkg and wbr_store.

module wbr_dp
    import wbr_pkg::*;
#(
    parameter int TABLE_COUNT  = TABLE_COUNT_DEF,
    parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
    parameter int NOTE_MAX     = NOTE_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wbr_cmd_t                   cmd,
    output wbr_sts_t                   sts,
    input  logic                       cfg_we,
    input  logic [TBL_W-1:0]           cfg_data,
    input  logic [TBL_W-1:0]           s_table_index,
    input  logic [ADDR_W-1:0]          s_sample_address,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic [NOTE_W-1:0]          s_note,
    input  logic [NUM_W-1:0]           s_sample_number,
    output logic signed [SAMPLE_W-1:0] m_resampled_value
);

    localparam int IDX_W     = $clog2(TABLE_LENGTH);
    localparam int MEM_DEPTH = TABLE_COUNT * TABLE_LENGTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int OCT_MAX   = NOTE_MAX / 12;
    localparam int OCT_W     = $clog2(OCT_MAX + 1);
    localparam int R_W       = ROM_W + OCT_MAX;
    localparam int S_W       = IDX_W + FRAC_W;
    localparam int X_W       = ((R_W > S_W) ? R_W : S_W) + 1;
    localparam int C_W       = R_W - FRAC_W + 1;
    localparam int SUM_W     = R_W + 2;
    localparam int NUM_DW    = R_W + 19;
    localparam int W_W       = FRAC_W + 1;
    localparam int T_W       = SAMPLE_W + 2;

    localparam logic [X_W-1:0]    MOD_M    = X_W'(TABLE_LENGTH) << FRAC_W;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_LENGTH - 1);
    localparam logic [W_W-1:0]    W_ONE    = W_W'(1) << FRAC_W;

    // Registers
    logic [TBL_W-1:0]           active_table_reg;
    logic [NOTE_W-1:0]          note_reg;
    logic [NUM_W-1:0]           n_reg;
    logic [MEM_AW-1:0]          base_reg;
    logic [R_W-1:0]             r_reg;
    logic [X_W-1:0]             rm_reg;
    logic [X_W-1:0]             acc_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [C_W-1:0]             cnt_reg;
    logic [W_W-1:0]             wf_reg;
    logic [FRAC_W-1:0]          fe_reg;
    logic                       first_reg;
    logic                       p1_valid_reg;
    logic                       p1_first_reg;
    logic                       p1_last_reg;
    logic                       p2_valid_reg;
    logic signed [T_W-1:0]      term_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [NUM_DW-1:0]          rem_reg;
    logic [NUM_DW-1:0]          dsh_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    // Combinational helpers
    logic                       tbl_ok;
    logic                       wr_ok;
    logic [NOTE_W-1:0]          note_sat;
    logic [14:0]                oct_prod;
    logic [3:0]                 oct4;
    logic [NOTE_W-1:0]          semi_full;
    logic [R_W-1:0]             ratio;
    logic [X_W-1:0]             dbl;
    logic [X_W-1:0]             addn;
    logic [S_W-1:0]             pos;
    logic [R_W:0]               fsr;
    logic                       we;
    logic [MEM_AW-1:0]          waddr;
    logic [MEM_AW-1:0]          raddr;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [W_W-1:0]      rd_ext;
    logic [W_W-1:0]             mag;
    logic [W_W-1:0]             wgt;
    logic [2*W_W-1:0]           prod;
    logic signed [T_W-1:0]      edge_term;
    logic signed [SUM_W-1:0]    sum_abs;
    logic [NUM_DW-1:0]          rem_sub;
    logic [QUO_W-2:0]           qsat;
    logic signed [SAMPLE_W-1:0] result;

    // Range checks
    assign tbl_ok = 32'(active_table_reg) < TABLE_COUNT;
    assign wr_ok  = (32'(s_table_index) < TABLE_COUNT) &&
                    (32'(s_sample_address) < TABLE_LENGTH);

    // Sample write address
    assign we    = cmd.wr && wr_ok;
    assign waddr = MEM_AW'(s_table_index) * MEM_AW'(TABLE_LENGTH) +
                   MEM_AW'(s_sample_address);

    // Clamp the note
    assign note_sat = (32'(s_note) > NOTE_MAX) ? NOTE_W'(NOTE_MAX) : s_note;

    // Split the note into octave and semitone: note / 12 as (note * 171) >> 11
    assign oct_prod  = 15'(note_reg) * 15'd171;
    assign oct4      = oct_prod[14:11];
    assign semi_full = note_reg - NOTE_W'(NOTE_W'(oct4) * NOTE_W'(12));
    assign ratio     = R_W'(octave_ratio(semi_full[3:0])) << oct4[OCT_W-1:0];

    // Modular multiply steps, each result below twice the span
    assign dbl  = acc_reg << 1;
    assign addn = acc_reg + (n_reg[NUM_W-1] ? rm_reg : X_W'(0));

    // Window start split
    assign pos = acc_reg[S_W-1:0];
    assign fsr = (R_W+1)'(pos[FRAC_W-1:0]) + (R_W+1)'(r_reg);

    // Read address of the window walk
    assign raddr = base_reg + MEM_AW'(idx_reg);

    wbr_store #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_sample_value),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Edge weighting, truncated toward zero
    assign rd_ext    = W_W'(signed'(rdata));
    assign mag       = rd_ext[W_W-1] ? W_W'(-rd_ext) : W_W'(rd_ext);
    assign wgt       = p1_first_reg ? wf_reg : W_W'(fe_reg);
    assign prod      = mag * wgt;
    assign edge_term = rd_ext[W_W-1] ? -T_W'(prod[FRAC_W+W_W-1:FRAC_W])
                                     : T_W'(prod[FRAC_W+W_W-1:FRAC_W]);

    // Divider helpers
    assign sum_abs = (sum_reg < 0) ? -sum_reg : sum_reg;
    assign rem_sub = rem_reg - dsh_reg;
    assign qsat    = (quo_reg > RES_MAX) ? RES_MAX[QUO_W-2:0] : quo_reg[QUO_W-2:0];
    assign result  = neg_reg ? -SAMPLE_W'(qsat) : SAMPLE_W'(qsat);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_table_reg <= '0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                active_table_reg <= cfg_data;
            end
            p1_valid_reg <= cmd.rd;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Capture, ratio and position
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            note_reg <= note_sat;
            n_reg    <= s_sample_number;
            base_reg <= MEM_AW'(active_table_reg) * MEM_AW'(TABLE_LENGTH);
        end else if (cmd.madd) begin
            n_reg <= n_reg << 1;
        end

        if (cmd.ratio) begin
            r_reg  <= ratio;
            rm_reg <= X_W'(ratio);
        end else if (cmd.rmod) begin
            rm_reg <= rm_reg - MOD_M;
        end

        if (cmd.ratio) begin
            acc_reg <= '0;
        end else if (cmd.mdbl) begin
            acc_reg <= (dbl >= MOD_M) ? dbl - MOD_M : dbl;
        end else if (cmd.madd) begin
            acc_reg <= (addn >= MOD_M) ? addn - MOD_M : addn;
        end
    end

    // Window walk
    always_ff @(posedge aclk) begin
        if (cmd.span) begin
            idx_reg   <= pos[S_W-1:FRAC_W];
            cnt_reg   <= fsr[R_W:FRAC_W];
            fe_reg    <= fsr[FRAC_W-1:0];
            wf_reg    <= W_ONE - W_W'(pos[FRAC_W-1:0]);
            first_reg <= 1'b1;
        end else if (cmd.rd) begin
            idx_reg   <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            cnt_reg   <= cnt_reg - 1'b1;
            first_reg <= 1'b0;
        end
        p1_first_reg <= first_reg;
        p1_last_reg  <= (cnt_reg == '0);
    end

    // Weigh and accumulate
    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            term_reg <= (p1_first_reg || p1_last_reg) ? edge_term
                                                      : T_W'(signed'(rdata));
        end
        if (cmd.span) begin
            sum_reg <= '0;
        end else if (p2_valid_reg) begin
            sum_reg <= sum_reg + SUM_W'(term_reg);
        end
    end

    // Rounding divider: (2 * |sum| * 65536 + r) / (2 * r), one bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.dinit) begin
            neg_reg <= (sum_reg < 0);
            rem_reg <= (NUM_DW'(unsigned'(sum_abs)) << (FRAC_W + 1)) + NUM_DW'(r_reg);
            dsh_reg <= NUM_DW'({r_reg, 1'b0}) << (QUO_W - 1);
            quo_reg <= '0;
        end else if (cmd.dstep) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.oload) begin
            out_reg <= cmd.ozero ? '0 : result;
        end
    end

    assign m_resampled_value = out_reg;

    assign sts.tbl_ok = tbl_ok;
    assign sts.rm_ge  = (rm_reg >= MOD_M);
    assign sts.last   = (cnt_reg == '0);
    assign sts.busy   = p1_valid_reg || p2_valid_reg;

endmodule

[rtl/wbr_ctrl.sv]
// Controller of the wavetable box resampler: sequences capture, ratio reduction,
// modular multiply, window walk, division and output handoff.
// Depends on wbr_pkg for the command and status structs.

module wbr_ctrl
    import wbr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_command,
    output logic     m_valid,
    input  logic     m_ready,
    input  wbr_sts_t sts,
    output wbr_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RATIO = 4'd1;
    localparam logic [3:0] ST_RMOD  = 4'd2;
    localparam logic [3:0] ST_MDBL  = 4'd3;
    localparam logic [3:0] ST_MADD  = 4'd4;
    localparam logic [3:0] ST_SPAN  = 4'd5;
    localparam logic [3:0] ST_READ  = 4'd6;
    localparam logic [3:0] ST_DRAIN = 4'd7;
    localparam logic [3:0] ST_DINIT = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              zero_reg, zero_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        zero_next    = zero_reg;
        m_valid_next = (m_valid_reg && !m_ready);
        cmd          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_WRITE) begin
                        cmd.wr = 1'b1;
                    end else begin
                        cmd.cap    = 1'b1;
                        zero_next  = !sts.tbl_ok;
                        state_next = sts.tbl_ok ? ST_RATIO : ST_OUT;
                    end
                end
            end
            ST_RATIO: begin
                cmd.ratio  = 1'b1;
                state_next = ST_RMOD;
            end
            ST_RMOD: begin
                if (sts.rm_ge) begin
                    cmd.rmod = 1'b1;
                end else begin
                    step_next  = STEP_W'(NUM_W - 1);
                    state_next = ST_MDBL;
                end
            end
            ST_MDBL: begin
                cmd.mdbl   = 1'b1;
                state_next = ST_MADD;
            end
            ST_MADD: begin
                cmd.madd = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_SPAN;
                end else begin
                    step_next  = step_reg - 1'b1;
                    state_next = ST_MDBL;
                end
            end
            ST_SPAN: begin
                cmd.span   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd = 1'b1;
                if (sts.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.dinit  = 1'b1;
                step_next  = STEP_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.dstep = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free, then hand off the word
                if (out_free) begin
                    cmd.oload    = 1'b1;
                    cmd.ozero    = zero_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/wavetable_box_resampler_unit.sv]
// Wavetable box resampler: stores wavetables and returns box-filtered reads at a
// semitone pitch ratio. Depends on wbr_pkg, wbr_ctrl and wbr_dp.
//
// Usage:
//   Input words (s_*) either write one table sample (s_command = 0) or request
//   one resampled value (s_command = 1). A write returns nothing; writes may
//   follow each other in every cycle.
//   A read returns one word on m_resampled_value. It first makes the ratio
//   reductions by the table span (none for the default table length), then forms
//   the window start with the modular position multiply and walks a window of
//   ((position fraction + ratio) >> 16) + 1 table samples, about 1536 at note
//   127. The window walk reads one sample per cycle through the single read
//   port of the sample memory; the rounding divider then forms the result.
//   s_ready is low while a read is in progress. A finished word waits in the
//   output register while the next input word is accepted; if the receiver
//   still stalls when the following read ends, that read holds until the
//   register empties.
//   cfg_data selects the active table; cfg_ready is always high.
//   Reset clears the control state and the active table; table contents stay
//   undefined until written.

module wavetable_box_resampler_unit
    import wbr_pkg::*;
#(
    parameter int TABLE_COUNT  = TABLE_COUNT_DEF,
    parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
    parameter int NOTE_MAX     = NOTE_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [TBL_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic [TBL_W-1:0]           s_table_index,
    input  logic [ADDR_W-1:0]          s_sample_address,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic [NOTE_W-1:0]          s_note,
    input  logic [NUM_W-1:0]           s_sample_number,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_resampled_value
);

    wbr_cmd_t cmd;
    wbr_sts_t sts;

    // Always take configuration words
    assign cfg_ready = 1'b1;

    wbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wbr_dp #(
        .TABLE_COUNT  (TABLE_COUNT),
        .TABLE_LENGTH (TABLE_LENGTH),
        .NOTE_MAX     (NOTE_MAX)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .s_table_index     (s_table_index),
        .s_sample_address  (s_sample_address),
        .s_sample_value    (s_sample_value),
        .s_note            (s_note),
        .s_sample_number   (s_sample_number),
        .m_resampled_value (m_resampled_value)
    );

endmodule

[rtl/wbr_checker.sv]
// Port-level checks for the wavetable box resampler, bound to the top level.
// Depends on wbr_pkg for field widths.

module wbr_checker
    import wbr_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_command,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_resampled_value
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resampled_value))
        else $error("output word changed or dropped while stalled");

    // Never emit the most negative code
    a_out_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_resampled_value != 16'sh8000)
        else $error("output not saturated");

    // Drop ready after accepting a read word
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_READ |=> !s_ready)
        else $error("input taken while a read is in progress");

    // Clear the output after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind wavetable_box_resampler_unit wbr_checker u_wbr_checker (.*);

[bench/testbench.sv]
// Self-checking bench for wavetable_box_resampler_unit: table fills, edge-case reads,
// then random write/read traffic under three sender/receiver pacing mixes.
// Depends on wbr_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench
    import wbr_pkg::*;
();

    localparam logic [TBL_W-1:0] TBL_BASE = 5'd0;
    localparam logic [TBL_W-1:0] TBL_MID  = 5'd17;
    localparam logic [TBL_W-1:0] TBL_TOP  = 5'd31;

    localparam longint unsigned TBL_LEN = TABLE_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 200;

    // Filled region on each side of the table wrap point
    localparam int FILL_HALF = 32;
    // Largest note whose window fits the filled region
    localparam int READ_NOTE_MAX = 59;
    localparam int PICK_TRIES = 100_000;

    // Semitone ratios in Q16.16, one octave
    localparam longint unsigned SEMITONE_Q16 [12] = '{
        65536, 69433, 73562, 77936, 82570, 87480,
        92682, 98193, 104032, 110218, 116772, 123715
    };

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [TBL_W-1:0]           cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_command = CMD_WRITE;
    logic [TBL_W-1:0]           s_table_index = '0;
    logic [ADDR_W-1:0]          s_sample_address = '0;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic [NOTE_W-1:0]          s_note = '0;
    logic [NUM_W-1:0]           s_sample_number = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_resampled_value;

    // Predictor state: table contents, which entries hold data, and the selected table
    bit signed [SAMPLE_W-1:0]   table_image [TABLE_COUNT_DEF * TABLE_LENGTH_DEF];
    bit                         written [TABLE_COUNT_DEF * TABLE_LENGTH_DEF];
    logic [TBL_W-1:0]           active_tbl = '0;
    logic signed [SAMPLE_W-1:0] pending_averages [$];
    logic signed [SAMPLE_W-1:0] want_value;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_checked = 0;

    wavetable_box_resampler_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_table_index     (s_table_index),
        .s_sample_address  (s_sample_address),
        .s_sample_value    (s_sample_value),
        .s_note            (s_note),
        .s_sample_number   (s_sample_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_resampled_value (m_resampled_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each result word with the oldest pending average
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_averages.size() == 0) begin
                fail_count++;
                $display("%0t: result word with none pending: expected none, actual %0d",
                         $time, m_resampled_value);
            end else begin
                want_value = pending_averages.pop_front();
                n_checked++;
                if (m_resampled_value !== want_value) begin
                    fail_count++;
                    $display("%0t: resampled_value mismatch: expected %0d, actual %0d",
                             $time, want_value, m_resampled_value);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_averages.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Weight an edge sample by its covered fraction, truncating toward zero
    function automatic longint edge_share(input logic signed [SAMPLE_W-1:0] smp,
                                          input longint unsigned wt);
        longint unsigned mag;
        longint part;
        mag = (smp < 0) ? -longint'(smp) : longint'(smp);
        part = longint'((mag * wt) >> FRAC_W);
        return (smp < 0) ? -part : part;
    endfunction

    // Box average of the table over [n*r, n*r + r), rounded half away from zero
    function automatic logic signed [SAMPLE_W-1:0] predict_average(
        input logic [TBL_W-1:0] tbl, input logic [NOTE_W-1:0] nt, input logic [NUM_W-1:0] num);
        longint unsigned span, ratio, start, stop, first_i, last_i, idx, k, n64, mag, quo;
        longint sum, scaled;
        longint unsigned base;
        logic [SAMPLE_W-1:0] res;
        span = TBL_LEN << FRAC_W;
        n64 = num;
        ratio = SEMITONE_Q16[nt % 12] << (nt / 12);
        start = (n64 * ratio) % span;
        stop = start + ratio;
        first_i = start >> FRAC_W;
        last_i = stop >> FRAC_W;
        base = longint'(tbl) * TBL_LEN;
        sum = edge_share(table_image[base + first_i % TBL_LEN], 65536 - (start & 64'hFFFF));
        idx = (first_i + 1) % TBL_LEN;
        for (k = 0; k < last_i - first_i - 1; k++) begin
            sum += table_image[base + idx];
            idx = (idx + 1) % TBL_LEN;
        end
        sum += edge_share(table_image[base + last_i % TBL_LEN], stop & 64'hFFFF);
        scaled = sum * 65536;
        mag = (scaled < 0) ? -scaled : scaled;
        quo = (2 * mag + ratio) / (2 * ratio);
        if (quo > 32767) quo = 32767;
        res = quo[SAMPLE_W-1:0];
        if (scaled < 0) res = -res;
        return res;
    endfunction

    // True when every entry that the read window touches holds data
    function automatic bit window_written(input logic [TBL_W-1:0] tbl,
                                          input logic [NOTE_W-1:0] nt,
                                          input logic [NUM_W-1:0] num);
        longint unsigned ratio, start, stop, first_i, last_i, base, n64;
        n64 = num;
        ratio = SEMITONE_Q16[nt % 12] << (nt / 12);
        start = (n64 * ratio) % (TBL_LEN << FRAC_W);
        stop = start + ratio;
        first_i = start >> FRAC_W;
        last_i = stop >> FRAC_W;
        base = longint'(tbl) * TBL_LEN;
        for (longint unsigned i = first_i; i <= last_i; i++) begin
            if (!written[base + i % TBL_LEN]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Pick a random read whose window lies in written entries of the active table
    task automatic pick_read(output logic [NOTE_W-1:0] nt, output logic [NUM_W-1:0] num);
        int tries;
        tries = 0;
        nt = NOTE_W'($urandom_range(READ_NOTE_MAX));
        num = NUM_W'($urandom);
        while (!window_written(active_tbl, nt, num) && tries < PICK_TRIES) begin
            nt = NOTE_W'($urandom_range(READ_NOTE_MAX));
            num = NUM_W'($urandom);
            tries++;
        end
        // fall back to the first two samples, always filled
        if (!window_written(active_tbl, nt, num)) begin
            nt = '0;
            num = '0;
        end
    endtask

    // Send one input word, then update the predictor at acceptance
    task automatic send_word(input logic cmd, input logic [TBL_W-1:0] tbl,
                             input logic [ADDR_W-1:0] addr,
                             input logic signed [SAMPLE_W-1:0] val,
                             input logic [NOTE_W-1:0] nt, input logic [NUM_W-1:0] num);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_table_index    <= tbl;
        s_sample_address <= addr;
        s_sample_value   <= val;
        s_note           <= nt;
        s_sample_number  <= num;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_WRITE) begin
            table_image[int'(tbl) * TABLE_LENGTH_DEF + int'(addr)] = val;
            written[int'(tbl) * TABLE_LENGTH_DEF + int'(addr)] = 1'b1;
            n_writes++;
        end else begin
            pending_averages.push_back(predict_average(active_tbl, nt, num));
            n_reads++;
        end
    endtask

    // Drop valid and hold until every pending result word has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_averages.size() != 0) @(posedge aclk);
    endtask

    // Switch the active table while the block is idle
    task automatic select_table(input logic [TBL_W-1:0] tbl);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= tbl;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        active_tbl = tbl;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Fill a region around the wrap point of every table that reads may select
    task automatic fill_tables();
        logic [TBL_W-1:0] tbl;
        for (int t = 0; t < 3; t++) begin
            tbl = (t == 0) ? TBL_BASE : (t == 1) ? TBL_MID : TBL_TOP;
            for (int a = -FILL_HALF; a < FILL_HALF; a++) begin
                send_word(CMD_WRITE, tbl, ADDR_W'(a + TABLE_LENGTH_DEF), SAMPLE_W'($urandom),
                          NOTE_W'($urandom), NUM_W'($urandom));
            end
        end
    endtask

    // Field extremes, saturation of the most negative sample, window wrap, reset table
    task automatic test_edge_cases();
        send_word(CMD_WRITE, TBL_BASE, 12'd0, 16'sd32767, '0, '0);
        send_word(CMD_WRITE, TBL_BASE, 12'd1, 16'sh8000, '0, '0);
        send_word(CMD_WRITE, TBL_BASE, 12'd2, -16'sd32767, '0, '0);
        send_word(CMD_WRITE, TBL_BASE, 12'd4095, 16'sd0, '0, '0);
        send_word(CMD_WRITE, TBL_TOP, 12'd4095, 16'sh8000, '0, '0);
        send_word(CMD_WRITE, TBL_TOP, 12'd0, 16'sd32767, '0, '0);
        // Reads from table 0, selected by reset alone
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'd0);
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'd1);
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'd2);
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'hFFFF_FFFF);
        // Widest window inside the filled region, from the start and before the wrap
        send_word(CMD_READ, '0, '0, '0, 7'd59, 32'd0);
        send_word(CMD_READ, '0, '0, '0, 7'd59, 32'hFFFF_FFFF);
        // Window that starts in the last sample and wraps with fractions on both edges
        send_word(CMD_READ, '0, '0, '0, 7'd1, 32'd3866);
        // Window that ends exactly at the table end
        send_word(CMD_READ, '0, '0, '0, 7'd24, 32'd1023);
        send_word(CMD_READ, '0, '0, '0, 7'd11, 32'd5);
        send_word(CMD_READ, '0, '0, '0, 7'd12, 32'd1);
        select_table(TBL_TOP);
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'd4095);
        send_word(CMD_READ, '0, '0, '0, 7'd0, 32'd4096);
        send_word(CMD_READ, '0, '0, '0, 7'd48, 32'h8000_0000);
    endtask

    // Random writes anywhere and reads from written windows of the selected table
    task automatic test_random_traffic(input int items, input int tx_idle,
                                       input int rx_stall, input logic [TBL_W-1:0] tbl);
        logic [NOTE_W-1:0] nt;
        logic [NUM_W-1:0]  num;
        select_table(tbl);
        sender_idle_pct = tx_idle;
        receiver_stall_pct = rx_stall;
        for (int i = 0; i < items; i++) begin
            // hold off once mid-phase until the block is empty
            if (i == items / 2) wait_drained();
            if ($urandom_range(99) < 60) begin
                pick_read(nt, num);
                send_word(CMD_READ, TBL_W'($urandom), ADDR_W'($urandom),
                          SAMPLE_W'($urandom), nt, num);
            end else begin
                send_word(CMD_WRITE, TBL_W'($urandom), ADDR_W'($urandom),
                          SAMPLE_W'($urandom), NOTE_W'($urandom), NUM_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct = 38;
        receiver_stall_pct = 73;
        fill_tables();
        test_edge_cases();
        test_random_traffic(54, 38, 73, TBL_TOP);
        test_random_traffic(54, 73, 38, TBL_MID);
        test_random_traffic(54, 0, 0, TBL_BASE);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d sample writes and %0d resampled reads over tables 0, 17 and 31",
                 n_writes, n_reads);
        $display("Checked %0d result words, %0d mismatches", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
